FILE: sv/rv32s_pkg.sv
`timescale 1ns / 1ps

package rv32s_pkg;

   localparam int unsigned XLEN         = 32;
   localparam int unsigned REG_COUNT    = 32;
   localparam int unsigned REG_AW       = $clog2(REG_COUNT);
   localparam int unsigned STORE_WORDS  = 1024;
   localparam int unsigned STORE_AW     = $clog2(STORE_WORDS);
   localparam int unsigned STORE_ADDR_W = 10;
   localparam int unsigned OUTQ_DEPTH   = 4;
   localparam int unsigned OUTQ_AW      = $clog2(OUTQ_DEPTH);
   localparam int unsigned RSP_DATA_W   = 152;

   // major opcodes
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_REG    = 7'b0110011;
   localparam logic [6:0] OPC_IMM    = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [6:0] F7_MULD = 7'b0000001;

   localparam logic [2:0] F3_ADD = 3'b000;
   localparam logic [2:0] F3_OR  = 3'b110;
   localparam logic [2:0] F3_AND = 3'b111;

   typedef logic [XLEN-1:0]         word_type;
   typedef logic [REG_AW-1:0]       reg_idx_type;
   typedef logic [STORE_AW-1:0]     ws_idx_type;
   typedef logic [STORE_ADDR_W-1:0] store_addr_type;
   typedef logic [OUTQ_AW:0]        outq_count_type;
   typedef logic [OUTQ_AW+1:0]      outq_load_type;

   localparam outq_load_type OUTQ_LIMIT = outq_load_type'(OUTQ_DEPTH);

   typedef struct packed {
      word_type       instr_pc;
      word_type       next_pc;
      logic           rd_write;
      reg_idx_type    rd_index;
      word_type       rd_value;
      logic           store_write;
      store_addr_type store_addr;
      word_type       store_data;
      logic           unknown_op;
   } rsp_type;

   typedef struct packed {
      logic        en;
      reg_idx_type idx;
      word_type    data;
   } rf_wr_type;

endpackage

FILE: sv/rv32s_regfile.sv
`timescale 1ns / 1ps

module rv32s_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  rv32s_pkg::reg_idx_type rs1_idx,
   input  rv32s_pkg::reg_idx_type rs2_idx,
   input  rv32s_pkg::rf_wr_type   wr,
   output rv32s_pkg::word_type    rs1_data,
   output rv32s_pkg::word_type    rs2_data
);

   rv32s_pkg::word_type rf_mem [rv32s_pkg::REG_COUNT];

   logic [rv32s_pkg::REG_COUNT-1:0] valid_ff;
   rv32s_pkg::word_type             rs1_raw_ff;
   rv32s_pkg::word_type             rs2_raw_ff;
   logic                            rs1_ok_ff;
   logic                            rs2_ok_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rf_mem[wr.idx] <= wr.data;
      end
      rs1_raw_ff <= rf_mem[rs1_idx];
      rs2_raw_ff <= rf_mem[rs2_idx];
   end

   // entries never written read as zero, x0 included
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rs1_ok_ff <= 1'b0;
         rs2_ok_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.idx] <= 1'b1;
         end
         rs1_ok_ff <= valid_ff[rs1_idx];
         rs2_ok_ff <= valid_ff[rs2_idx];
      end
   end

   assign rs1_data = rs1_ok_ff ? rs1_raw_ff : '0;
   assign rs2_data = rs2_ok_ff ? rs2_raw_ff : '0;

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> wr.idx != '0)
      else $error("write to x0 reached the register file");

   a_x0_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rs1_idx == '0 |=> rs1_data == '0)
      else $error("x0 read returned nonzero");

endmodule

FILE: sv/rv32s_store.sv
`timescale 1ns / 1ps

module rv32s_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  rv32s_pkg::ws_idx_type wr_addr,
   input  rv32s_pkg::word_type   wr_data,
   input  rv32s_pkg::ws_idx_type rd_addr,
   output rv32s_pkg::word_type   rd_data,
   output logic                  busy
);

   rv32s_pkg::word_type ws_mem [rv32s_pkg::STORE_WORDS];

   rv32s_pkg::ws_idx_type clr_idx_ff;
   logic                  busy_ff;
   rv32s_pkg::word_type   rd_data_ff;

   logic                  mem_we;
   rv32s_pkg::ws_idx_type mem_wa;
   rv32s_pkg::word_type   mem_wd;

   // clearing pass owns the write port until every word is zero
   always_comb begin
      mem_we = busy_ff | wr_en;
      mem_wa = busy_ff ? clr_idx_ff : wr_addr;
      mem_wd = busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ws_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= ws_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == '1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

   a_no_store_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !wr_en)
      else $error("store issued during clearing pass");

endmodule

FILE: sv/rv32s_outq.sv
`timescale 1ns / 1ps

module rv32s_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rv32s_pkg::rsp_type        push_word,
   input  logic                      pop,
   output logic                      head_valid,
   output rv32s_pkg::rsp_type        head_word,
   output rv32s_pkg::outq_count_type count
);

   rv32s_pkg::rsp_type q_mem [rv32s_pkg::OUTQ_DEPTH];

   logic [rv32s_pkg::OUTQ_AW-1:0] wr_ptr_ff;
   logic [rv32s_pkg::OUTQ_AW-1:0] rd_ptr_ff;
   rv32s_pkg::outq_count_type     count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head_valid = count_ff != '0;
   assign head_word  = q_mem[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != rv32s_pkg::outq_count_type'(rv32s_pkg::OUTQ_DEPTH))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");

endmodule

FILE: sv/rv32_subset_instruction_execute.sv
// channel  dir  tdata fields (low bit up)                                      tuser
// req_     in   instr[31:0]                                                     -
// rsp_     out  instr_pc, next_pc, rd_write, rd_index, rd_value, store_write,   unknown_op
//               store_addr, store_data, 7 zero pad bits
//
// one instruction per cycle while req_tready is high: accept reads the register file,
// the next cycle executes and issues the word-store access, the one after writes back
// (load data from the store port) and pushes the result word into a 4-deep queue
// operands are forwarded from write-back and the last completed write, so no stalls
// after reset a clearing pass zeroes all 1024 words of the store; req_tready stays low meanwhile
// req_tready drops while the store clears and when the result queue could not hold every word in flight
`timescale 1ns / 1ps

module rv32_subset_instruction_execute (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [31:0]                           req_tdata,  // instr
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rv32s_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // instr_pc, next_pc, rd_write,
                                                              // rd_index, rd_value, store_write,
                                                              // store_addr, store_data
   output logic                                  rsp_tuser   // unknown_op
);

   logic req_fire;
   logic rsp_fire;

   // execute stage
   logic                 e_valid_ff;
   rv32s_pkg::word_type  e_instr_ff;
   rv32s_pkg::word_type  pc_ff;

   // write-back stage
   logic                 w_valid_ff;
   logic                 w_load_ff;
   rv32s_pkg::rsp_type   w_rsp_ff;
   rv32s_pkg::rf_wr_type lw_ff;

   rv32s_pkg::word_type  rf_rs1_data;
   rv32s_pkg::word_type  rf_rs2_data;
   rv32s_pkg::rf_wr_type rf_wr;
   rv32s_pkg::word_type  w_value;

   rv32s_pkg::word_type   ws_rd_data;
   logic                  ws_busy;
   logic                  ws_wr_en;
   rv32s_pkg::ws_idx_type ws_idx;

   rv32s_pkg::rsp_type        q_head;
   logic                      q_valid;
   rv32s_pkg::outq_count_type q_count;
   rv32s_pkg::outq_load_type  q_load;
   rv32s_pkg::rsp_type        w_out;

   logic [6:0]             opc;
   rv32s_pkg::reg_idx_type rd;
   rv32s_pkg::reg_idx_type rs1;
   rv32s_pkg::reg_idx_type rs2;
   logic [2:0]             f3;
   logic [6:0]             f7;
   rv32s_pkg::word_type    imm_i;
   rv32s_pkg::word_type    imm_s;
   rv32s_pkg::word_type    imm_b;
   rv32s_pkg::word_type    imm_j;
   rv32s_pkg::word_type    op_a;
   rv32s_pkg::word_type    op_b;
   rv32s_pkg::word_type    mul_lo;
   rv32s_pkg::word_type    pc_plus4;
   rv32s_pkg::word_type    ea;
   rv32s_pkg::rsp_type     e_rsp;
   logic                   e_wr;
   logic                   e_load;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   assign q_load = {1'b0, q_count}
                 + {{(rv32s_pkg::OUTQ_AW + 1){1'b0}}, e_valid_ff}
                 + {{(rv32s_pkg::OUTQ_AW + 1){1'b0}}, w_valid_ff};
   assign req_tready = !ws_busy && (q_load < rv32s_pkg::OUTQ_LIMIT);

   // write-back: load data arrives from the store read port this cycle
   assign w_value = w_load_ff ? ws_rd_data : w_rsp_ff.rd_value;

   always_comb begin
      rf_wr.en   = w_valid_ff && w_rsp_ff.rd_write;
      rf_wr.idx  = w_rsp_ff.rd_index;
      rf_wr.data = w_value;
      w_out          = w_rsp_ff;
      w_out.rd_value = w_value;
   end

   rv32s_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rs1_idx  (req_tdata[19:15]),
      .rs2_idx  (req_tdata[24:20]),
      .wr       (rf_wr),
      .rs1_data (rf_rs1_data),
      .rs2_data (rf_rs2_data)
   );

   // decode and execute
   always_comb begin
      opc   = e_instr_ff[6:0];
      rd    = e_instr_ff[11:7];
      f3    = e_instr_ff[14:12];
      rs1   = e_instr_ff[19:15];
      rs2   = e_instr_ff[24:20];
      f7    = e_instr_ff[31:25];
      imm_i = {{20{e_instr_ff[31]}}, e_instr_ff[31:20]};
      imm_s = {{20{e_instr_ff[31]}}, e_instr_ff[31:25], e_instr_ff[11:7]};
      imm_b = {{20{e_instr_ff[31]}}, e_instr_ff[7], e_instr_ff[30:25],
               e_instr_ff[11:8], 1'b0};
      imm_j = {{12{e_instr_ff[31]}}, e_instr_ff[19:12], e_instr_ff[20],
               e_instr_ff[30:21], 1'b0};

      // newest writer wins: write-back, then the last completed write, then the array
      op_a = rf_rs1_data;
      if (lw_ff.en && lw_ff.idx == rs1) begin
         op_a = lw_ff.data;
      end
      if (rf_wr.en && rf_wr.idx == rs1) begin
         op_a = w_value;
      end
      op_b = rf_rs2_data;
      if (lw_ff.en && lw_ff.idx == rs2) begin
         op_b = lw_ff.data;
      end
      if (rf_wr.en && rf_wr.idx == rs2) begin
         op_b = w_value;
      end

      mul_lo   = op_a * op_b;
      pc_plus4 = pc_ff + 32'd4;
      ea       = op_a + ((opc == rv32s_pkg::OPC_STORE) ? imm_s : imm_i);
      ws_idx   = ea[rv32s_pkg::STORE_AW-1:0];

      e_rsp             = '0;
      e_rsp.instr_pc    = pc_ff;
      e_rsp.next_pc     = pc_plus4;
      e_wr              = 1'b0;
      e_load            = 1'b0;

      unique case (opc)
         rv32s_pkg::OPC_REG: begin
            e_wr = 1'b1;
            unique case ({f7, f3})
               {rv32s_pkg::F7_BASE, rv32s_pkg::F3_ADD}: e_rsp.rd_value = op_a + op_b;
               {rv32s_pkg::F7_ALT,  rv32s_pkg::F3_ADD}: e_rsp.rd_value = op_a - op_b;
               {rv32s_pkg::F7_BASE, rv32s_pkg::F3_AND}: e_rsp.rd_value = op_a & op_b;
               {rv32s_pkg::F7_BASE, rv32s_pkg::F3_OR}:  e_rsp.rd_value = op_a | op_b;
               {rv32s_pkg::F7_MULD, rv32s_pkg::F3_ADD}: e_rsp.rd_value = mul_lo;
               default: begin
                  e_wr             = 1'b0;
                  e_rsp.unknown_op = 1'b1;
               end
            endcase
         end
         rv32s_pkg::OPC_IMM: begin
            e_wr = 1'b1;
            unique case (f3)
               rv32s_pkg::F3_ADD: e_rsp.rd_value = op_a + imm_i;
               rv32s_pkg::F3_AND: e_rsp.rd_value = op_a & imm_i;
               rv32s_pkg::F3_OR:  e_rsp.rd_value = op_a | imm_i;
               default: begin
                  e_wr             = 1'b0;
                  e_rsp.unknown_op = 1'b1;
               end
            endcase
         end
         rv32s_pkg::OPC_LOAD: begin
            e_wr   = 1'b1;
            e_load = 1'b1;
         end
         rv32s_pkg::OPC_STORE: begin
            e_rsp.store_write = 1'b1;
            e_rsp.store_addr  = rv32s_pkg::store_addr_type'(ws_idx);
            e_rsp.store_data  = op_b;
         end
         rv32s_pkg::OPC_BRANCH: begin
            if (op_a == op_b) begin
               e_rsp.next_pc = pc_ff + imm_b;
            end
         end
         rv32s_pkg::OPC_JAL: begin
            e_wr           = 1'b1;
            e_rsp.rd_value = pc_plus4;
            e_rsp.next_pc  = pc_ff + imm_j;
         end
         default: begin
            e_rsp.unknown_op = 1'b1;
         end
      endcase

      // x0 as destination drops the write
      if (rd == '0) begin
         e_wr   = 1'b0;
         e_load = 1'b0;
      end
      e_rsp.rd_write = e_wr;
      e_rsp.rd_index = e_wr ? rd : '0;
      if (!e_wr || e_load) begin
         e_rsp.rd_value = '0;
      end

      ws_wr_en = e_valid_ff && e_rsp.store_write;
   end

   rv32s_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ws_wr_en),
      .wr_addr (ws_idx),
      .wr_data (op_b),
      .rd_addr (ws_idx),
      .rd_data (ws_rd_data),
      .busy    (ws_busy)
   );

   always_ff @(posedge clock) begin
      e_instr_ff <= req_tdata;
      w_rsp_ff   <= e_rsp;
      w_load_ff  <= e_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
         lw_ff      <= '0;
         pc_ff      <= '0;
      end else begin
         e_valid_ff <= req_fire;
         w_valid_ff <= e_valid_ff;
         lw_ff      <= rf_wr;
         if (e_valid_ff) begin
            pc_ff <= e_rsp.next_pc;
         end
      end
   end

   rv32s_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (w_valid_ff),
      .push_word  (w_out),
      .pop        (rsp_fire),
      .head_valid (q_valid),
      .head_word  (q_head),
      .count      (q_count)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tdata  = {7'b0, q_head.store_data, q_head.store_addr, q_head.store_write,
                        q_head.rd_value, q_head.rd_index, q_head.rd_write,
                        q_head.next_pc, q_head.instr_pc};
   assign rsp_tuser  = q_head.unknown_op;

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_load <= rv32s_pkg::OUTQ_LIMIT)
      else $error("more words in flight than the result queue holds");

   a_pc_follows: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |=> pc_ff == $past(e_rsp.next_pc))
      else $error("pc did not take next_pc of the executed word");

endmodule

FILE: dv/rv32_subset_instruction_execute_checker.sv
`timescale 1ns / 1ps

module rv32_subset_instruction_execute_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // instr
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rv32s_pkg::RSP_DATA_W-1:0] rsp_tdata,   // instr_pc, next_pc, rd_write,
                                                         // rd_index, rd_value, store_write,
                                                         // store_addr, store_data
   input  logic                             rsp_tuser,   // unknown_op
   output int                               failures,
   output int                               pending,
   output int                               compared,
   output int                               flagged
);

   // architectural shadow state
   rv32s_pkg::word_type pc_model;
   rv32s_pkg::word_type gpr [rv32s_pkg::REG_COUNT];
   rv32s_pkg::word_type dmem [rv32s_pkg::STORE_WORDS];

   rv32s_pkg::rsp_type retire_q [$];
   int errors        = 0;
   int result_count  = 0;
   int unknown_count = 0;

   function automatic rv32s_pkg::rsp_type execute_instr(input rv32s_pkg::word_type ins);
      rv32s_pkg::rsp_type r;
      logic [6:0] opc;
      logic [6:0] f7;
      logic [2:0] f3;
      rv32s_pkg::reg_idx_type rd;
      rv32s_pkg::word_type a;
      rv32s_pkg::word_type b;
      rv32s_pkg::word_type imm;
      rv32s_pkg::word_type addr;
      rv32s_pkg::word_type val;
      logic wr;
      opc = ins[6:0];
      rd  = ins[11:7];
      f3  = ins[14:12];
      f7  = ins[31:25];
      a   = (ins[19:15] == '0) ? '0 : gpr[ins[19:15]];
      b   = (ins[24:20] == '0) ? '0 : gpr[ins[24:20]];
      imm = {{20{ins[31]}}, ins[31:20]};
      r = '0;
      r.instr_pc = pc_model;
      r.next_pc  = pc_model + 32'd4;
      wr  = 1'b0;
      val = '0;
      case (opc)
         rv32s_pkg::OPC_REG: begin
            wr = 1'b1;
            if (f7 == rv32s_pkg::F7_BASE && f3 == rv32s_pkg::F3_ADD) val = a + b;
            else if (f7 == rv32s_pkg::F7_ALT && f3 == rv32s_pkg::F3_ADD) val = a - b;
            else if (f7 == rv32s_pkg::F7_BASE && f3 == rv32s_pkg::F3_AND) val = a & b;
            else if (f7 == rv32s_pkg::F7_BASE && f3 == rv32s_pkg::F3_OR) val = a | b;
            else if (f7 == rv32s_pkg::F7_MULD && f3 == rv32s_pkg::F3_ADD) val = a * b;
            else begin
               wr = 1'b0;
               r.unknown_op = 1'b1;
            end
         end
         rv32s_pkg::OPC_IMM: begin
            wr = 1'b1;
            if (f3 == rv32s_pkg::F3_ADD) val = a + imm;
            else if (f3 == rv32s_pkg::F3_AND) val = a & imm;
            else if (f3 == rv32s_pkg::F3_OR) val = a | imm;
            else begin
               wr = 1'b0;
               r.unknown_op = 1'b1;
            end
         end
         rv32s_pkg::OPC_LOAD: begin
            addr = a + imm;
            wr   = 1'b1;
            val  = dmem[addr[rv32s_pkg::STORE_AW-1:0]];
         end
         rv32s_pkg::OPC_STORE: begin
            // width code ignored, always a full word
            addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            r.store_write = 1'b1;
            r.store_addr  = addr[rv32s_pkg::STORE_ADDR_W-1:0];
            r.store_data  = b;
            dmem[addr[rv32s_pkg::STORE_AW-1:0]] = b;
         end
         rv32s_pkg::OPC_BRANCH: begin
            // every branch compares for equality
            if (a == b)
               r.next_pc = pc_model +
                  {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
         end
         rv32s_pkg::OPC_JAL: begin
            wr  = 1'b1;
            val = pc_model + 32'd4;
            r.next_pc = pc_model +
               {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
         end
         default: r.unknown_op = 1'b1;
      endcase
      // writes to x0 vanish
      if (wr && rd != '0) begin
         gpr[rd]    = val;
         r.rd_write = 1'b1;
         r.rd_index = rd;
         r.rd_value = val;
      end
      pc_model = r.next_pc;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input rv32s_pkg::word_type got,
                                  input rv32s_pkg::word_type want);
      errors++;
      if (errors <= 40)
         $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
   endtask

   task automatic compare_field(input string what, input rv32s_pkg::word_type got,
                                input rv32s_pkg::word_type want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : watch
      rv32s_pkg::rsp_type got;
      rv32s_pkg::rsp_type want;
      if (reset) begin
         pc_model = '0;
         foreach (gpr[i]) gpr[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         retire_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            retire_q.insert(retire_q.size(), execute_instr(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.instr_pc    = rsp_tdata[31:0];
            got.next_pc     = rsp_tdata[63:32];
            got.rd_write    = rsp_tdata[64];
            got.rd_index    = rsp_tdata[69:65];
            got.rd_value    = rsp_tdata[101:70];
            got.store_write = rsp_tdata[102];
            got.store_addr  = rsp_tdata[112:103];
            got.store_data  = rsp_tdata[144:113];
            got.unknown_op  = rsp_tuser;
            if (retire_q.size() == 0) begin
               report_mismatch("word with no instruction pending, pc", got.instr_pc, '0);
            end else begin
               want = retire_q.pop_front();
               result_count++;
               if (want.unknown_op) unknown_count++;
               compare_field("instr_pc", got.instr_pc, want.instr_pc);
               compare_field("next_pc", got.next_pc, want.next_pc);
               compare_field("rd_write", rv32s_pkg::word_type'(got.rd_write),
                             rv32s_pkg::word_type'(want.rd_write));
               compare_field("rd_index", rv32s_pkg::word_type'(got.rd_index),
                             rv32s_pkg::word_type'(want.rd_index));
               compare_field("rd_value", got.rd_value, want.rd_value);
               compare_field("store_write", rv32s_pkg::word_type'(got.store_write),
                             rv32s_pkg::word_type'(want.store_write));
               compare_field("store_addr", rv32s_pkg::word_type'(got.store_addr),
                             rv32s_pkg::word_type'(want.store_addr));
               compare_field("store_data", got.store_data, want.store_data);
               compare_field("unknown_op", rv32s_pkg::word_type'(got.unknown_op),
                             rv32s_pkg::word_type'(want.unknown_op));
            end
         end
      end
      failures <= errors;
      pending  <= retire_q.size();
      compared <= result_count;
      flagged  <= unknown_count;
   end

endmodule

FILE: dv/rv32_subset_instruction_execute_tb.sv
`timescale 1ns / 1ps

module rv32_subset_instruction_execute_tb;

   localparam int RANDOM_ITEMS = 1430;
   localparam int DIRECTED     = 27;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 80;

   // codes not in the package
   localparam logic [2:0] F3_EQ   = 3'b000;
   localparam logic [2:0] F3_NE   = 3'b001;
   localparam logic [2:0] F3_SLL  = 3'b001;
   localparam logic [2:0] F3_WORD = 3'b010;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rv32s_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;

   int failures;
   int pending;
   int compared;
   int flagged;
   int issued   = 0;
   bit quiet    = 1'b0;
   bit flood    = 1'b0;
   bit hold_rsp = 1'b0;

   rv32_subset_instruction_execute DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rv32_subset_instruction_execute_checker retire_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending),
      .compared   (compared),
      .flagged    (flagged)
   );

   initial forever #6 clock = ~clock;

   function automatic rv32s_pkg::word_type enc_r(input logic [6:0] f7,
                                                 input rv32s_pkg::reg_idx_type rs2,
                                                 input rv32s_pkg::reg_idx_type rs1,
                                                 input logic [2:0] f3,
                                                 input rv32s_pkg::reg_idx_type rd);
      return {f7, rs2, rs1, f3, rd, rv32s_pkg::OPC_REG};
   endfunction

   function automatic rv32s_pkg::word_type enc_i(input logic [6:0] opc, input logic [11:0] imm,
                                                 input rv32s_pkg::reg_idx_type rs1,
                                                 input logic [2:0] f3,
                                                 input rv32s_pkg::reg_idx_type rd);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic rv32s_pkg::word_type enc_s(input logic [11:0] imm,
                                                 input rv32s_pkg::reg_idx_type rs2,
                                                 input rv32s_pkg::reg_idx_type rs1,
                                                 input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32s_pkg::OPC_STORE};
   endfunction

   function automatic rv32s_pkg::word_type enc_b(input logic [12:0] imm,
                                                 input rv32s_pkg::reg_idx_type rs2,
                                                 input rv32s_pkg::reg_idx_type rs1,
                                                 input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32s_pkg::OPC_BRANCH};
   endfunction

   function automatic rv32s_pkg::word_type enc_j(input logic [20:0] imm,
                                                 input rv32s_pkg::reg_idx_type rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32s_pkg::OPC_JAL};
   endfunction

   // mostly a small register pool so results feed straight back as operands
   function automatic rv32s_pkg::reg_idx_type pick_reg();
      if ($urandom_range(0, 3) != 0)
         return rv32s_pkg::reg_idx_type'($urandom_range(0, 7));
      return rv32s_pkg::reg_idx_type'($urandom_range(0, 31));
   endfunction

   function automatic rv32s_pkg::word_type random_instr();
      int unsigned sel;
      logic [6:0]  f7;
      logic [2:0]  f3;
      logic [11:0] imm12;
      logic [20:0] imm21;
      rv32s_pkg::reg_idx_type rs1;
      rv32s_pkg::reg_idx_type rs2;
      rv32s_pkg::reg_idx_type rd;
      sel   = $urandom_range(0, 99);
      rs1   = pick_reg();
      rs2   = pick_reg();
      rd    = pick_reg();
      f7    = 7'($urandom);
      f3    = 3'($urandom_range(0, 7));
      imm12 = 12'($urandom);
      imm21 = 21'($urandom);
      imm21[0] = 1'b0;
      if (sel < 25) begin
         case ($urandom_range(0, 4))
            0: return enc_r(rv32s_pkg::F7_BASE, rs2, rs1, rv32s_pkg::F3_ADD, rd);
            1: return enc_r(rv32s_pkg::F7_ALT, rs2, rs1, rv32s_pkg::F3_ADD, rd);
            2: return enc_r(rv32s_pkg::F7_BASE, rs2, rs1, rv32s_pkg::F3_AND, rd);
            3: return enc_r(rv32s_pkg::F7_BASE, rs2, rs1, rv32s_pkg::F3_OR, rd);
            default: return enc_r(rv32s_pkg::F7_MULD, rs2, rs1, rv32s_pkg::F3_ADD, rd);
         endcase
      end
      if (sel < 30) begin
         // near-miss function codes
         if ($urandom_range(0, 1)) f7 = f7 & (rv32s_pkg::F7_ALT | rv32s_pkg::F7_MULD);
         return enc_r(f7, rs2, rs1, f3, rd);
      end
      if (sel < 50) begin
         case ($urandom_range(0, 2))
            0: f3 = rv32s_pkg::F3_ADD;
            1: f3 = rv32s_pkg::F3_AND;
            default: f3 = rv32s_pkg::F3_OR;
         endcase
         return enc_i(rv32s_pkg::OPC_IMM, imm12, rs1, f3, rd);
      end
      if (sel < 53)
         return enc_i(rv32s_pkg::OPC_IMM, imm12, rs1, f3, rd);
      // half the memory traffic hits a small window so loads see earlier stores
      if (sel < 73 && $urandom_range(0, 1)) begin
         rs1   = '0;
         imm12 = 12'($urandom_range(0, 31));
      end
      if (sel < 63)
         return enc_i(rv32s_pkg::OPC_LOAD, imm12, rs1, f3, rd);
      if (sel < 73)
         return enc_s(imm12, rs2, rs1, f3);
      if (sel < 83) begin
         if ($urandom_range(0, 1)) rs2 = rs1;
         return enc_b({imm12, 1'b0}, rs2, rs1, f3);
      end
      if (sel < 88)
         return enc_j(imm21, rd);
      return $urandom;
   endfunction

   task automatic issue(input rv32s_pkg::word_type w);
      if (!quiet && !flood && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      issued++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // result side: random stalls, plus one long hold on request
   initial begin : result_sink
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: %0d cycles without a word moving", idle_cycles);
      $display("rv32_subset_instruction_execute regression: fail");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      issue(enc_i(rv32s_pkg::OPC_IMM, 12'hFFF, 5'd0, rv32s_pkg::F3_ADD, 5'd1));  // x1 = -1
      issue(enc_i(rv32s_pkg::OPC_IMM, 12'h7FF, 5'd0, rv32s_pkg::F3_ADD, 5'd2));  // x2 = 2047
      issue(enc_r(rv32s_pkg::F7_BASE, 5'd2, 5'd1, rv32s_pkg::F3_ADD, 5'd3));
      issue(enc_r(rv32s_pkg::F7_ALT, 5'd1, 5'd2, rv32s_pkg::F3_ADD, 5'd4));
      issue(enc_r(rv32s_pkg::F7_BASE, 5'd2, 5'd1, rv32s_pkg::F3_AND, 5'd5));
      issue(enc_r(rv32s_pkg::F7_BASE, 5'd4, 5'd2, rv32s_pkg::F3_OR, 5'd6));
      issue(enc_r(rv32s_pkg::F7_MULD, 5'd1, 5'd1, rv32s_pkg::F3_ADD, 5'd7));
      issue(enc_r(rv32s_pkg::F7_MULD, 5'd2, 5'd2, rv32s_pkg::F3_ADD, 5'd8));
      issue(enc_i(rv32s_pkg::OPC_IMM, 12'h800, 5'd1, rv32s_pkg::F3_AND, 5'd9));
      issue(enc_i(rv32s_pkg::OPC_IMM, 12'h555, 5'd0, rv32s_pkg::F3_OR, 5'd10));
      issue(enc_s(12'hFFF, 5'd1, 5'd0, F3_WORD));                     // wraps to top index
      issue(enc_i(rv32s_pkg::OPC_LOAD, 12'hFFF, 5'd0, F3_WORD, 5'd11));
      issue(enc_i(rv32s_pkg::OPC_LOAD, 12'h7FF, 5'd1, F3_WORD, 5'd12)); // never written
      issue(enc_s(12'h7FF, 5'd2, 5'd1, F3_WORD));
      issue(enc_i(rv32s_pkg::OPC_LOAD, 12'h3FE, 5'd0, F3_WORD, 5'd13)); // aliased read back
      issue(enc_i(rv32s_pkg::OPC_IMM, 12'h005, 5'd1, rv32s_pkg::F3_ADD, 5'd0));  // x0 target
      issue(enc_r(rv32s_pkg::F7_BASE, 5'd1, 5'd0, rv32s_pkg::F3_ADD, 5'd14));
      issue(enc_b(13'h0008, 5'd1, 5'd1, F3_EQ));
      issue(enc_b(13'h0010, 5'd1, 5'd2, F3_NE));               // unequal, falls through
      issue(enc_b(13'h1000, 5'd0, 5'd0, F3_EQ));               // most negative offset
      issue(enc_j(21'h000004, 5'd15));
      issue(enc_j(21'h100000, 5'd0));
      issue(enc_j(21'h0FFFFE, 5'd16));
      issue(enc_r(rv32s_pkg::F7_ALT, 5'd2, 5'd1, rv32s_pkg::F3_AND, 5'd17));    // unsupported
      issue(enc_i(rv32s_pkg::OPC_IMM, 12'h003, 5'd1, F3_SLL, 5'd18));  // shift, unsupported
      issue(32'h0000_0000);
      issue(32'hFFFF_FFFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) begin
            hold_rsp = 1'b1;
            flood    = 1'b1;
         end
         if (i == 340) flood = 1'b0;
         if (i == 700) wait_drained();
         if (i == 1250) quiet = 1'b1;
         issue(random_instr());
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);

      $display("ran %0d instructions (%0d directed): all ops, x0 writes, aliased stores,",
               issued, DIRECTED);
      $display("branches both ways and jal links; %0d words compared, %0d unsupported",
               compared, flagged);
      if (failures == 0 && pending == 0)
         $display("rv32_subset_instruction_execute regression: pass");
      else
         $display("rv32_subset_instruction_execute regression: fail");
      $finish;
   end

endmodule
